/* design/sci_pkg.sv */
// ----------------------------------------------------------------------------
// sci_pkg
// Widths, limits, types and helpers for the segment crossing interpolator.
// ----------------------------------------------------------------------------
package sci_pkg;

  localparam int CW = 32;            // coordinate width, Q16.16
  localparam int FB = 16;            // fraction bits
  localparam int DW = CW + 1;        // coordinate difference width
  localparam int XW = 2 * DW + 1;    // cross product width
  localparam int RW = XW + 1;        // divider partial remainder width
  localparam int QW = CW;            // quotient bits, one per divider stage
  localparam int PW = DW + CW;       // lerp product width
  localparam int AW = PW + 1;        // lerp accumulator width

  localparam logic [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

  localparam logic KIND_STRIP = 1'b0;
  localparam logic KIND_CROSS = 1'b1;

  typedef struct packed {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
    logic signed [CW-1:0] tx;
    logic signed [CW-1:0] ty;
    logic signed [CW-1:0] tz;
  } sci_side_t;

  typedef struct packed {
    logic neg;
    logic ovf;
    logic par;
  } sci_flag_t;

  // saturate a wide signed value to CW bits
  function automatic logic [CW-1:0] sci_sat(logic signed [AW-1:0] v);
    logic [AW-CW:0] top;
    begin
      top = v[AW-1:CW-1];
      if (top == '0 || top == '1) begin
        sci_sat = v[CW-1:0];
      end else if (v[AW-1]) begin
        sci_sat = T_MIN;
      end else begin
        sci_sat = T_MAX;
      end
    end
  endfunction

endpackage

/* design/sci_if.sv */
// ----------------------------------------------------------------------------
// sci channel interfaces
// Valid/ready channels for crossing items and interpolated results.
// ----------------------------------------------------------------------------
interface sci_in_if import sci_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic signed [CW-1:0] p_x;
  logic signed [CW-1:0] p_y;
  logic signed [CW-1:0] q_x;
  logic signed [CW-1:0] q_y;
  logic signed [CW-1:0] from_x;
  logic signed [CW-1:0] from_y;
  logic signed [CW-1:0] from_z;
  logic signed [CW-1:0] to_x;
  logic signed [CW-1:0] to_y;
  logic signed [CW-1:0] to_z;

  modport source (output valid, kind, p_x, p_y, q_x, q_y, from_x, from_y, from_z,
                  to_x, to_y, to_z, input ready);
  modport sink (input valid, kind, p_x, p_y, q_x, q_y, from_x, from_y, from_z,
                to_x, to_y, to_z, output ready);
endinterface

interface sci_out_if import sci_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] param_t;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [CW-1:0] pos_z;
  logic                 parallel;

  modport source (output valid, param_t, pos_x, pos_y, pos_z, parallel, input ready);
  modport sink (input valid, param_t, pos_x, pos_y, pos_z, parallel, output ready);
endinterface

/* design/sci_div_step.sv */
// ----------------------------------------------------------------------------
// sci_div_step
// One restoring division step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
module sci_div_step import sci_pkg::*; (
  input  logic [RW-1:0] rem_i,
  input  logic [XW-1:0] den_i,
  input  logic          bit_i,
  output logic [RW-1:0] rem_o,
  output logic          q_o
);

  logic [RW-1:0] shifted;
  logic [RW:0]   diff;

  always_comb begin
    shifted = {rem_i[RW-2:0], bit_i};
    diff    = {1'b0, shifted} - {2'b00, den_i};
    q_o     = ~diff[RW];
    rem_o   = q_o ? diff[RW-1:0] : shifted;
  end

endmodule

/* design/segment_crossing_interpolator_top.sv */
// ----------------------------------------------------------------------------
// segment_crossing_interpolator_top
// Strip/edge crossing parameter and 3D lerp in Q16.16 with saturation.
// ----------------------------------------------------------------------------
// Takes one transaction per clock and delivers one result per clock when the
// sink keeps ready high. A strip-start transaction updates origin and
// direction at once and gives no result. A crossing transaction passes forty
// register stages, the first loaded at the accepting edge: five stages for
// differences, cross products, magnitudes and the parallel test, a 32-stage
// restoring divider that settles one bit of t per stage, then saturation of t,
// the lerp multiply and the final truncation and clamp. The whole pipeline
// holds while the output register is full and not taken. min_cross is
// sampled in the fifth stage and should only be written when no crossing is
// in flight.
module segment_crossing_interpolator_top import sci_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  sci_in_if.sink            in_ch,
  sci_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CW-1:0]     cfg_wdata
);

  logic ce;

  // configuration and strip state
  logic [CW-1:0]        min_cross_r;
  logic signed [CW-1:0] origin_x_r, origin_y_r;
  logic signed [DW-1:0] dir_x_r, dir_y_r;

  // stage 0: differences
  logic                 s0_vld_r;
  logic signed [DW-1:0] s0_a_r, s0_b_r, s0_c_r, s0_d_r, s0_dx_r, s0_dy_r;
  sci_side_t            s0_side_r, s0_side_nxt;
  logic                 take;

  // stage 1: products
  logic                   s1_vld_r;
  logic signed [2*DW-1:0] s1_p0_r, s1_p1_r, s1_p2_r, s1_p3_r;
  sci_side_t              s1_side_r;

  // stage 2: cross products
  logic                 s2_vld_r;
  logic signed [XW-1:0] s2_cr_r, s2_nm_r;
  sci_side_t            s2_side_r;

  // stage 3: magnitudes
  logic          s3_vld_r, s3_neg_r;
  logic [XW-1:0] s3_dmag_r, s3_nmag_r;
  sci_side_t     s3_side_r;

  // divider pipe, index 0 is the setup stage
  logic          dv_vld_r  [0:QW];
  logic [RW-1:0] dv_rem_r  [0:QW];
  logic [XW-1:0] dv_den_r  [0:QW];
  logic [QW-1:0] dv_nlo_r  [0:QW];
  logic [QW-1:0] dv_q_r    [0:QW];
  sci_flag_t     dv_flg_r  [0:QW];
  sci_side_t     dv_side_r [0:QW];
  sci_flag_t     flg_nxt;

  // t, lerp product, output
  logic                 t_vld_r, t_par_r;
  logic signed [CW-1:0] t_r, t_nxt;
  sci_side_t            t_side_r;
  logic                 m_vld_r, m_par_r;
  logic signed [CW-1:0] m_t_r;
  logic signed [PW-1:0] m_px_r, m_py_r, m_pz_r;
  logic signed [CW-1:0] m_tx_r, m_ty_r, m_tz_r;
  logic                 o_vld_r, o_par_r;
  logic [CW-1:0]        o_t_r, o_x_r, o_y_r, o_z_r;

  assign ce          = ~o_vld_r | out_ch.ready;
  assign in_ch.ready = ce;
  assign take        = in_ch.valid & ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_cross_r <= CW'(43);
    end else if (cfg_we) begin
      min_cross_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      dir_x_r    <= '0;
      dir_y_r    <= '0;
    end else if (take && in_ch.kind == KIND_STRIP) begin
      origin_x_r <= in_ch.p_x;
      origin_y_r <= in_ch.p_y;
      dir_x_r    <= DW'(in_ch.q_x) - DW'(in_ch.p_x);
      dir_y_r    <= DW'(in_ch.q_y) - DW'(in_ch.p_y);
    end
  end

  always_comb begin
    s0_side_nxt.dx = DW'(in_ch.from_x) - DW'(in_ch.to_x);
    s0_side_nxt.dy = DW'(in_ch.from_y) - DW'(in_ch.to_y);
    s0_side_nxt.dz = DW'(in_ch.from_z) - DW'(in_ch.to_z);
    s0_side_nxt.tx = in_ch.to_x;
    s0_side_nxt.ty = in_ch.to_y;
    s0_side_nxt.tz = in_ch.to_z;
  end

  // valid chain up to the divider setup stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r    <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      dv_vld_r[0] <= 1'b0;
    end else if (ce) begin
      s0_vld_r    <= in_ch.valid & (in_ch.kind == KIND_CROSS);
      s1_vld_r    <= s0_vld_r;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      dv_vld_r[0] <= s3_vld_r;
    end
  end

  always_comb begin
    flg_nxt.neg = s3_neg_r;
    flg_nxt.par = (s3_dmag_r == '0) || (s3_dmag_r < XW'(min_cross_r));
    flg_nxt.ovf = XW'(s3_nmag_r[XW-1:QW-FB]) >= s3_dmag_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s0_a_r    <= DW'(in_ch.p_x) - DW'(in_ch.q_x);
      s0_b_r    <= DW'(in_ch.p_y) - DW'(in_ch.q_y);
      s0_c_r    <= DW'(origin_x_r) - DW'(in_ch.q_x);
      s0_d_r    <= DW'(origin_y_r) - DW'(in_ch.q_y);
      s0_dx_r   <= dir_x_r;
      s0_dy_r   <= dir_y_r;
      s0_side_r <= s0_side_nxt;

      s1_p0_r   <= s0_a_r * s0_dy_r;
      s1_p1_r   <= s0_b_r * s0_dx_r;
      s1_p2_r   <= s0_c_r * s0_dy_r;
      s1_p3_r   <= s0_d_r * s0_dx_r;
      s1_side_r <= s0_side_r;

      s2_cr_r   <= XW'(s1_p0_r) - XW'(s1_p1_r);
      s2_nm_r   <= XW'(s1_p2_r) - XW'(s1_p3_r);
      s2_side_r <= s1_side_r;

      s3_dmag_r <= s2_cr_r[XW-1] ? XW'(-s2_cr_r) : XW'(s2_cr_r);
      s3_nmag_r <= s2_nm_r[XW-1] ? XW'(-s2_nm_r) : XW'(s2_nm_r);
      s3_neg_r  <= s2_cr_r[XW-1] ^ s2_nm_r[XW-1];
      s3_side_r <= s2_side_r;

      // remainder starts with the dividend bits above the quotient span
      dv_rem_r[0]  <= RW'(s3_nmag_r[XW-1:QW-FB]);
      dv_den_r[0]  <= s3_dmag_r;
      dv_nlo_r[0]  <= {s3_nmag_r[QW-FB-1:0], FB'(0)};
      dv_q_r[0]    <= '0;
      dv_flg_r[0]  <= flg_nxt;
      dv_side_r[0] <= s3_side_r;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [RW-1:0] rem_w;
    logic          q_w;

    sci_div_step u_step (
      .rem_i (dv_rem_r[k-1]),
      .den_i (dv_den_r[k-1]),
      .bit_i (dv_nlo_r[k-1][QW-1]),
      .rem_o (rem_w),
      .q_o   (q_w)
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else if (ce) begin
        dv_vld_r[k] <= dv_vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        dv_rem_r[k]  <= rem_w;
        dv_den_r[k]  <= dv_den_r[k-1];
        dv_nlo_r[k]  <= {dv_nlo_r[k-1][QW-2:0], 1'b0};
        dv_q_r[k]    <= {dv_q_r[k-1][QW-2:0], q_w};
        dv_flg_r[k]  <= dv_flg_r[k-1];
        dv_side_r[k] <= dv_side_r[k-1];
      end
    end
  end

  // signed, saturated t
  always_comb begin
    if (dv_flg_r[QW].neg) begin
      if (dv_flg_r[QW].ovf || dv_q_r[QW] > T_MIN) begin
        t_nxt = T_MIN;
      end else begin
        t_nxt = CW'(-dv_q_r[QW]);
      end
    end else begin
      if (dv_flg_r[QW].ovf || dv_q_r[QW][QW-1]) begin
        t_nxt = T_MAX;
      end else begin
        t_nxt = dv_q_r[QW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
      m_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (ce) begin
      t_vld_r <= dv_vld_r[QW];
      m_vld_r <= t_vld_r;
      o_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      t_r      <= t_nxt;
      t_par_r  <= dv_flg_r[QW].par;
      t_side_r <= dv_side_r[QW];

      // from*t + to*(1-t) = to + (from-to)*t
      m_px_r  <= t_side_r.dx * t_r;
      m_py_r  <= t_side_r.dy * t_r;
      m_pz_r  <= t_side_r.dz * t_r;
      m_tx_r  <= t_side_r.tx;
      m_ty_r  <= t_side_r.ty;
      m_tz_r  <= t_side_r.tz;
      m_t_r   <= t_r;
      m_par_r <= t_par_r;

      o_par_r <= m_par_r;
      if (m_par_r) begin
        o_t_r <= '0;
        o_x_r <= '0;
        o_y_r <= '0;
        o_z_r <= '0;
      end else begin
        o_t_r <= m_t_r;
        o_x_r <= sci_sat((AW'(m_px_r) + (AW'(m_tx_r) <<< FB)) >>> FB);
        o_y_r <= sci_sat((AW'(m_py_r) + (AW'(m_ty_r) <<< FB)) >>> FB);
        o_z_r <= sci_sat((AW'(m_pz_r) + (AW'(m_tz_r) <<< FB)) >>> FB);
      end
    end
  end

  assign out_ch.valid    = o_vld_r;
  assign out_ch.param_t  = o_t_r;
  assign out_ch.pos_x    = o_x_r;
  assign out_ch.pos_y    = o_y_r;
  assign out_ch.pos_z    = o_z_r;
  assign out_ch.parallel = o_par_r;

endmodule

/* design/sci_checker.sv */
// ----------------------------------------------------------------------------
// sci_checker
// Port-level checks on the segment crossing interpolator, bound to the top.
// ----------------------------------------------------------------------------
module sci_checker import sci_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [CW-1:0] out_param_t,
  input logic [CW-1:0] out_pos_x,
  input logic [CW-1:0] out_pos_y,
  input logic [CW-1:0] out_pos_z,
  input logic          out_parallel
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_param_t) && $stable(out_pos_x)
      && $stable(out_pos_y) && $stable(out_pos_z) && $stable(out_parallel))
    else $error("result changed while stalled");

  // parallel results carry zero fields
  a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_parallel |-> out_param_t == '0 && out_pos_x == '0
      && out_pos_y == '0 && out_pos_z == '0)
    else $error("parallel result with nonzero fields");

  // no result straight out of reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the pipeline only holds while a result waits
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

endmodule

bind segment_crossing_interpolator_top sci_checker u_sci_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_param_t  (out_ch.param_t),
  .out_pos_x    (out_ch.pos_x),
  .out_pos_y    (out_ch.pos_y),
  .out_pos_z    (out_ch.pos_z),
  .out_parallel (out_ch.parallel)
);

/* test/segment_crossing_interpolator_top_tb.sv */
// ----------------------------------------------------------------------------
// segment_crossing_interpolator_top_tb
// Drives strip-start and crossing transactions with random idling on both
// channels, predicts t and the interpolated 3D point for every crossing, and
// compares each result field by field. Runs over several min_cross settings.
// ----------------------------------------------------------------------------
module segment_crossing_interpolator_top_tb;
  import sci_pkg::*;

  typedef struct packed {
    logic                 kind;
    logic signed [CW-1:0] p_x;
    logic signed [CW-1:0] p_y;
    logic signed [CW-1:0] q_x;
    logic signed [CW-1:0] q_y;
    logic signed [CW-1:0] from_x;
    logic signed [CW-1:0] from_y;
    logic signed [CW-1:0] from_z;
    logic signed [CW-1:0] to_x;
    logic signed [CW-1:0] to_y;
    logic signed [CW-1:0] to_z;
  } crossing_item_t;

  typedef struct packed {
    logic signed [CW-1:0] param_t;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic                 parallel;
  } crossing_result_t;

  class crossing_scoreboard;
    logic signed [CW-1:0] org_x, org_y;
    logic signed [DW-1:0] dir_x, dir_y;
    logic [31:0]          min_cross;
    crossing_result_t     expected_q[$];
    int                   errors;
    int                   checked;
    int                   n_parallel;

    function new();
      org_x = '0;
      org_y = '0;
      dir_x = '0;
      dir_y = '0;
      min_cross = 32'd43;
      errors = 0;
      checked = 0;
      n_parallel = 0;
    endfunction

    function logic signed [CW-1:0] clamp(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'h7fffffff;
      if (v < -128'sd2147483648) return 32'h80000000;
      return v[CW-1:0];
    endfunction

    function logic signed [127:0] lerp(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                                       logic signed [63:0] t, logic signed [63:0] s);
      logic signed [127:0] fa, fb, tt, ss;
      fa = a;
      fb = b;
      tt = t;
      ss = s;
      return (fa * tt + fb * ss) >>> FB;
    endfunction

    function void note_item(crossing_item_t it);
      logic signed [127:0] px, py, qx, qy, ox, oy, dx, dy, cr, num;
      logic [127:0]        mag, nmag, quo;
      logic [32:0]         tq;
      logic signed [63:0]  t, s;
      logic                neg;
      crossing_result_t    r;
      px = it.p_x;
      py = it.p_y;
      qx = it.q_x;
      qy = it.q_y;
      if (it.kind == KIND_STRIP) begin
        org_x = it.p_x;
        org_y = it.p_y;
        dx = qx - px;
        dy = qy - py;
        dir_x = dx[DW-1:0];
        dir_y = dy[DW-1:0];
        return;
      end
      ox = org_x;
      oy = org_y;
      dx = dir_x;
      dy = dir_y;
      cr = (px - qx) * dy - (py - qy) * dx;
      mag = cr[127] ? -cr : cr;
      r = '0;
      if (mag == 0 || mag < {96'b0, min_cross}) begin
        r.parallel = 1'b1;
        n_parallel++;
      end else begin
        num = (ox - qx) * dy - (oy - qy) * dx;
        nmag = num[127] ? -num : num;
        quo = (nmag << FB) / mag;
        neg = num[127] ^ cr[127];
        if (neg) begin
          tq = (quo > 128'h80000000) ? 33'h080000000 : quo[32:0];
          t = -$signed({31'b0, tq});
        end else begin
          tq = (quo > 128'h7fffffff) ? 33'h07fffffff : quo[32:0];
          t = $signed({31'b0, tq});
        end
        s = 64'sd65536 - t;
        r.param_t = t[CW-1:0];
        r.pos_x = clamp(lerp(it.from_x, it.to_x, t, s));
        r.pos_y = clamp(lerp(it.from_y, it.to_y, t, s));
        r.pos_z = clamp(lerp(it.from_z, it.to_z, t, s));
      end
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(crossing_result_t got);
      crossing_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction: %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch t=%h/%h x=%h/%h y=%h/%h z=%h/%h par=%b/%b (exp/act)",
                   want.param_t, got.param_t, want.pos_x, got.pos_x, want.pos_y,
                   got.pos_y, want.pos_z, got.pos_z, want.parallel, got.parallel);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [CW-1:0] cfg_wdata;
  logic        long_hold;
  logic        burst;
  logic signed [DW-1:0] gen_dir_x, gen_dir_y;
  int          n_items;
  crossing_scoreboard sb;

  sci_in_if  in_if ();
  sci_out_if out_if ();

  segment_crossing_interpolator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #6000000;
    $display("segment_crossing_interpolator_top_tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_item({in_if.kind, in_if.p_x, in_if.p_y, in_if.q_x, in_if.q_y,
                      in_if.from_x, in_if.from_y, in_if.from_z,
                      in_if.to_x, in_if.to_y, in_if.to_z});
      if (out_if.valid && out_if.ready)
        sb.check_result({out_if.param_t, out_if.pos_x, out_if.pos_y, out_if.pos_z,
                         out_if.parallel});
    end
  end

  // result side: random stalls per transaction, plus one long hold on request
  initial begin
    int n;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_if.ready = 1'b0;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
      end
      n = burst ? 0 : $urandom_range(0, 14);
      if (n > 0) begin
        out_if.ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return $urandom_range(0, 32'h00100000) - 32'h00080000;
      8: begin
        case ($urandom_range(0, 4))
          0: return 32'h80000000;
          1: return 32'h7fffffff;
          2: return 32'h0;
          3: return 32'hffffffff;
          default: return 32'h00010000;
        endcase
      end
      default: return $urandom_range(0, 131071) - 65536;
    endcase
  endfunction

  task automatic send_item(crossing_item_t it);
    int n;
    n = burst ? 0 : $urandom_range(0, 14);
    if (n > 0) begin
      in_if.valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_if.valid  = 1'b1;
    in_if.kind   = it.kind;
    in_if.p_x    = it.p_x;
    in_if.p_y    = it.p_y;
    in_if.q_x    = it.q_x;
    in_if.q_y    = it.q_y;
    in_if.from_x = it.from_x;
    in_if.from_y = it.from_y;
    in_if.from_z = it.from_z;
    in_if.to_x   = it.to_x;
    in_if.to_y   = it.to_y;
    in_if.to_z   = it.to_z;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    in_if.valid = 1'b0;
    n_items++;
    if (it.kind == KIND_STRIP) begin
      gen_dir_x = $signed(it.q_x) - $signed(it.p_x);
      gen_dir_y = $signed(it.q_y) - $signed(it.p_y);
    end
  endtask

  task automatic send_strip(logic signed [CW-1:0] ax, ay, bx, by);
    crossing_item_t it;
    it = '0;
    it.kind = KIND_STRIP;
    it.p_x = ax;
    it.p_y = ay;
    it.q_x = bx;
    it.q_y = by;
    it.from_x = $urandom;
    it.to_z = $urandom;
    send_item(it);
  endtask

  task automatic send_cross(logic signed [CW-1:0] px, py, qx, qy, fx, fy, fz, tx, ty, tz);
    crossing_item_t it;
    it = {KIND_CROSS, px, py, qx, qy, fx, fy, fz, tx, ty, tz};
    send_item(it);
  endtask

  task automatic send_random();
    logic signed [CW-1:0] px, py;
    if ($urandom_range(0, 5) == 0) begin
      send_strip(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end else begin
      px = rand_coord();
      py = rand_coord();
      if ($urandom_range(0, 7) == 0)
        send_cross(px, py, px - gen_dir_x[CW-1:0], py - gen_dir_y[CW-1:0], rand_coord(),
                   rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
      else
        send_cross(px, py, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end
    if ($urandom_range(0, 49) == 0) burst = ~burst;
  endtask

  // let the pipeline empty so min_cross can change safely
  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_min_cross(logic [31:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(posedge clk);
    sb.min_cross = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    logic [31:0] settings [4];
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    long_hold = 1'b0;
    burst = 1'b0;
    gen_dir_x = '0;
    gen_dir_y = '0;
    n_items = 0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_STRIP;
    {in_if.p_x, in_if.p_y, in_if.q_x, in_if.q_y} = '0;
    {in_if.from_x, in_if.from_y, in_if.from_z, in_if.to_x, in_if.to_y, in_if.to_z} = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // crossing before any strip: zero direction, so parallel
    send_cross(32'h10000, 0, -32'h10000, 0, 1, 2, 3, 4, 5, 6);
    // horizontal strip, vertical edge through its middle
    send_strip(-32'h20000, 0, 32'h20000, 0);
    send_cross(0, 32'h10000, 0, -32'h10000, 32'h10000, 32'h20000, 32'h30000,
               -32'h10000, -32'h20000, -32'h30000);
    send_cross(32'h8000, 32'h30000, 32'h8000, -32'h10000, 32'h7fffffff, 32'h80000000,
               0, 32'h80000000, 32'h7fffffff, 32'hffffffff);
    // edge parallel to strip
    send_cross(0, 32'h10000, 32'h40000, 32'h10000, 1, 1, 1, 1, 1, 1);
    // horizontal edges with a tiny x extent: zero cross, so parallel
    send_cross(0, 32'h7fff0000, 1, 32'h7fff0000, 32'h10000, 0, -32'h10000, 0, 0, 0);
    send_cross(0, 32'h10000, 32'h1, 32'h10000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
               32'h80000000, 32'h80000000, 32'h7fffffff);
    send_cross(0, 32'h10000, -32'h1, 32'h10000, 5, 6, 7, 8, 9, 10);
    // edge stops short of the strip line: t above one
    send_cross(32'h10000, 32'h10000, 32'h10000, 32'h30000, 32'h10000, 0, 0, 0, 32'h10000, 0);
    // extreme coordinates everywhere
    send_strip(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send_cross(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
               32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000);
    send_cross(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0, 0,
               32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_strip(0, 0, 0, 0);
    send_cross(32'h10000, 32'h10000, 0, 0, 1, 1, 1, 1, 1, 1);
    send_strip(0, 0, 32'h10000, 32'h10000);
    send_cross(32'h10000, 0, 0, 32'h10000, 32'h30000, 32'h30000, 32'h30000, 0, 0, 0);
    drain();

    settings[0] = 32'd0;
    settings[1] = 32'hffffffff;
    settings[2] = $urandom;
    settings[3] = 32'd43;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) write_min_cross(settings[ph-1]);
      if (ph == 2) long_hold = 1'b1;
      for (int k = 0; k < 210; k++) send_random();
      drain();
    end

    if (sb.expected_q.size() != 0) sb.errors++;
    $display("%0d transactions sent, %0d results checked (%0d parallel), 5 min_cross settings",
             n_items, sb.checked, sb.n_parallel);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("segment_crossing_interpolator_top_tb: clean");
    end else begin
      $display("segment_crossing_interpolator_top_tb: errors");
    end
    $finish;
  end

endmodule

/* files.f */
design/sci_pkg.sv
design/sci_if.sv
design/sci_div_step.sv
design/segment_crossing_interpolator_top.sv
design/sci_checker.sv
test/segment_crossing_interpolator_top_tb.sv
